// ===== hw/rtl/spsi_pkg.sv =====
`timescale 1ns / 1ps

package spsi_pkg;

  // Number of cells, one stored pair per cell.
  localparam int unsigned CAPACITY = 256;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    TOK_SEARCH,
    TOK_SHIFT,
    TOK_CLEAR
  } tok_mode_e;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_CLEAR  = 1'b1
  } kind_e;

  typedef struct packed {
    logic [63:0] first_key;
    logic [63:0] second_key;
  } pair_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] first_key;
    logic [63:0] second_key;
  } spsi_in_t;

  typedef struct packed {
    logic added;
    logic full_res;
  } spsi_out_t;

  // Token handed from cell to cell.
  typedef struct packed {
    logic      vld;
    tok_mode_e mode;
    logic      full;
    pair_t     pair;
  } token_t;

  // Result a cell raises when it settles a lookup.
  typedef struct packed {
    logic strobe;
    logic added;
    logic full_res;
  } cell_res_t;

endpackage

// ===== hw/rtl/spsi_cell.sv =====
`timescale 1ns / 1ps

module spsi_cell import spsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  token_t    tok_i,
  output token_t    tok_o,
  output cell_res_t res_o
);

  pair_t  ent_q, ent_d;
  logic   ent_vld_q, ent_vld_d;
  token_t tok_q, tok_d;

  always_comb begin
    ent_d     = ent_q;
    ent_vld_d = ent_vld_q;
    tok_d     = tok_i;
    tok_d.vld = 1'b0;
    res_o     = '0;
    if (tok_i.vld) begin
      case (tok_i.mode)
        TOK_CLEAR: begin
          // drop the entry, pass the sweep on
          ent_vld_d = 1'b0;
          tok_d.vld = 1'b1;
        end
        TOK_SHIFT: begin
          // take the carried pair, hand the old one down
          ent_d     = tok_i.pair;
          ent_vld_d = 1'b1;
          if (ent_vld_q) begin
            tok_d.vld  = 1'b1;
            tok_d.pair = ent_q;
          end
        end
        TOK_SEARCH: begin
          if (!ent_vld_q) begin
            res_o.strobe   = 1'b1;
            res_o.added    = !tok_i.full;
            res_o.full_res = tok_i.full;
            if (!tok_i.full) begin
              ent_d     = tok_i.pair;
              ent_vld_d = 1'b1;
            end
          end else if (ent_q == tok_i.pair) begin
            res_o.strobe = 1'b1;
          end else if (ent_q > tok_i.pair) begin
            res_o.strobe   = 1'b1;
            res_o.added    = !tok_i.full;
            res_o.full_res = tok_i.full;
            if (!tok_i.full) begin
              ent_d      = tok_i.pair;
              tok_d.vld  = 1'b1;
              tok_d.mode = TOK_SHIFT;
              tok_d.pair = ent_q;
            end
          end else begin
            tok_d.vld = 1'b1;
          end
        end
        default: begin
          tok_d.vld = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= 1'b0;
      tok_q     <= '0;
    end else begin
      ent_vld_q <= ent_vld_d;
      tok_q     <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign tok_o = tok_q;

endmodule

// ===== hw/rtl/sorted_pair_set_insert.sv =====
`timescale 1ns / 1ps
// A test-and-insert result is settled by one cell (0..CAPACITY-1): the first stored pair not
// below the key, else the first free cell; on a full set with every stored pair below
// the key it is settled when the token runs off the end of the chain. Results are registered.
// Throughput: one test-and-insert at a time, set by the token walking the cell chain one
// cell per cycle; a clear answers ahead of its sweep; the next one may follow at once.
// Reset: asynchronous active low; the set is empty after reset. The receiver cannot stall.

module sorted_pair_set_insert import spsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  spsi_in_t  in_i,
  output logic      busy_o,
  output logic      res_valid_o,
  output spsi_out_t res_o
);

  // Token chain: tok_w[0] is the injection register, tok_w[i+1] leaves cell i.
  token_t    tok_w [CAPACITY+1];
  cell_res_t cres_w [CAPACITY];

  token_t             inj_q, inj_d;
  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               res_valid_q, res_valid_d;
  spsi_out_t          res_q, res_d;

  logic accept;
  logic any_strobe, any_added, any_full;

  assign accept = start_i && !busy_q;

  assign tok_w[0] = inj_q;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spsi_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1]),
      .res_o  (cres_w[g])
    );
  end

  // Collect the one cell that settles the lookup this cycle. A search token that runs
  // off the end of the chain found every stored pair below its key on a full set.
  always_comb begin
    any_strobe = tok_w[CAPACITY].vld && (tok_w[CAPACITY].mode == TOK_SEARCH);
    any_added  = 1'b0;
    any_full   = any_strobe;
    for (int i = 0; i < CAPACITY; i++) begin
      any_strobe = any_strobe | cres_w[i].strobe;
      any_added  = any_added  | cres_w[i].added;
      any_full   = any_full   | cres_w[i].full_res;
    end
  end

  always_comb begin
    inj_d       = in_i.kind ? token_t'{vld: 1'b0, mode: TOK_CLEAR, full: 1'b0, pair: '0}
                            : token_t'{vld: 1'b0, mode: TOK_SEARCH, full: 1'b0, pair: '0};
    inj_d.pair  = '{first_key: in_i.first_key, second_key: in_i.second_key};
    inj_d.full  = (count_q == CNT_W'(CAPACITY));
    inj_d.vld   = accept;
    busy_d      = busy_q;
    count_d     = count_q;
    res_valid_d = 1'b0;
    res_d       = '0;

    // Settle the outstanding lookup: report it, free the port, bump the count if a pair was added.
    if (any_strobe) begin
      res_valid_d    = 1'b1;
      res_d.added    = any_added;
      res_d.full_res = any_full;
      busy_d         = 1'b0;
      if (any_added) begin
        count_d = count_q + CNT_W'(1);
      end
    end

    if (accept) begin
      if (in_i.kind == KIND_CLEAR) begin
        // Empty the set now; the clear sweep walks the cells behind us.
        count_d     = '0;
        res_valid_d = 1'b1;
        res_d       = '0;
      end else begin
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q       <= '0;
      busy_q      <= 1'b0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      inj_q       <= inj_d;
      busy_q      <= busy_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  assign busy_o      = busy_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
